@@ rtl/trdz_pkg.sv @@
// ----------------------------------------------------------------------------
// trdz_pkg
// Shared types and constants for the thumbstick radial dead zone pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trdz_pkg;

  localparam int MAG_W   = 16;
  localparam int SUM_W   = 33;
  localparam int M_W     = 17;
  localparam int SQ_REM_W = 35;
  localparam int PROD_W  = 33;
  localparam int DEN_W   = 33;
  localparam int NUM_W   = 48;
  localparam int Q_BITS  = 15;

  localparam logic [15:0] DZ_RESET   = 16'd13107;
  localparam logic [15:0] DZ_MAX     = 16'd65534;
  localparam logic [15:0] FULL_SCALE = 16'hFFFF;
  localparam logic [15:0] Q15_MAX    = 16'd32767;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               in_dead_zone;
  } result_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic             sx;
    logic             sy;
    logic [15:0]      dz;
  } sq_side_t;

  typedef struct packed {
    logic sx;
    logic sy;
    logic dead;
  } dv_side_t;

endpackage

`default_nettype wire

@@ rtl/trdz_sqrt.sv @@
// ----------------------------------------------------------------------------
// trdz_sqrt
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trdz_sqrt (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [trdz_pkg::SUM_W-1:0] in_v,
  input  wire trdz_pkg::sq_side_t      in_side,
  output logic                         out_valid,
  output logic [trdz_pkg::M_W-1:0]     out_m,
  output trdz_pkg::sq_side_t           out_side
);
  import trdz_pkg::*;

  logic [SQ_REM_W-1:0] rem  [M_W+1];
  logic [M_W-1:0]      root [M_W+1];
  logic                vld  [M_W+1];
  sq_side_t            side [M_W+1];

  assign rem[0]  = SQ_REM_W'(in_v);
  assign root[0] = '0;
  assign vld[0]  = in_valid;
  assign side[0] = in_side;

  for (genvar g = 0; g < M_W; g++) begin : g_stage
    localparam int BIT = M_W - 1 - g;
    logic [SQ_REM_W-1:0] d;
    logic                take;

    always_comb begin
      d    = (SQ_REM_W'(root[g]) << (BIT + 1)) + (SQ_REM_W'(1) << (2 * BIT));
      take = rem[g] >= d;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1]  <= take ? rem[g] - d : rem[g];
        root[g+1] <= take ? (root[g] | (M_W'(1) << BIT)) : root[g];
        side[g+1] <= side[g];
      end
    end
  end

  assign out_valid = vld[M_W];
  assign out_m     = root[M_W];
  assign out_side  = side[M_W];

endmodule

`default_nettype wire

@@ rtl/trdz_div.sv @@
// ----------------------------------------------------------------------------
// trdz_div
// Two-lane pipelined restoring divider with saturation detect, one quotient
// bit per register stage after the saturation stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trdz_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [trdz_pkg::NUM_W-1:0] num_x,
  input  wire logic [trdz_pkg::NUM_W-1:0] num_y,
  input  wire logic [trdz_pkg::DEN_W-1:0] den,
  input  wire trdz_pkg::dv_side_t         in_side,
  output logic                            out_valid,
  output logic [trdz_pkg::Q_BITS-1:0]     q_x,
  output logic [trdz_pkg::Q_BITS-1:0]     q_y,
  output logic                            sat_x,
  output logic                            sat_y,
  output trdz_pkg::dv_side_t              out_side
);
  import trdz_pkg::*;

  logic [NUM_W-1:0]  rx   [Q_BITS+1];
  logic [NUM_W-1:0]  ry   [Q_BITS+1];
  logic [DEN_W-1:0]  dd   [Q_BITS+1];
  logic [Q_BITS-1:0] qx   [Q_BITS+1];
  logic [Q_BITS-1:0] qy   [Q_BITS+1];
  logic              stx  [Q_BITS+1];
  logic              sty  [Q_BITS+1];
  logic              vld  [Q_BITS+1];
  dv_side_t          side [Q_BITS+1];

  // saturation stage: quotient exceeds 15 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0]   <= num_x;
      ry[0]   <= num_y;
      dd[0]   <= den;
      qx[0]   <= '0;
      qy[0]   <= '0;
      stx[0]  <= num_x >= (NUM_W'(den) << Q_BITS);
      sty[0]  <= num_y >= (NUM_W'(den) << Q_BITS);
      side[0] <= in_side;
    end
  end

  for (genvar g = 0; g < Q_BITS; g++) begin : g_stage
    localparam int BIT = Q_BITS - 1 - g;
    logic [NUM_W-1:0] ds;
    logic             tx;
    logic             ty;

    always_comb begin
      ds = NUM_W'(dd[g]) << BIT;
      tx = rx[g] >= ds;
      ty = ry[g] >= ds;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx[g+1]   <= tx ? rx[g] - ds : rx[g];
        ry[g+1]   <= ty ? ry[g] - ds : ry[g];
        qx[g+1]   <= tx ? (qx[g] | (Q_BITS'(1) << BIT)) : qx[g];
        qy[g+1]   <= ty ? (qy[g] | (Q_BITS'(1) << BIT)) : qy[g];
        dd[g+1]   <= dd[g];
        stx[g+1]  <= stx[g];
        sty[g+1]  <= sty[g];
        side[g+1] <= side[g];
      end
    end
  end

  assign out_valid = vld[Q_BITS];
  assign q_x       = qx[Q_BITS];
  assign q_y       = qy[Q_BITS];
  assign sat_x     = stx[Q_BITS];
  assign sat_y     = sty[Q_BITS];
  assign out_side  = side[Q_BITS];

endmodule

`default_nettype wire

@@ rtl/thumbstick_radial_dead_zone.sv @@
// ----------------------------------------------------------------------------
// thumbstick_radial_dead_zone
// Radial dead zone with rescaling for one thumbstick sample, Q1.15 output.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the result side does not stall and
// returns one result per sample, in order, through s1 to s3, the 17-stage
// square root, s4, s5, the 16-stage divider and the output register. A
// stall on the result side holds the whole pipeline and is passed straight
// back to the sample side. Dead zone settings above 65534 act as 65534.
`timescale 1ns / 1ps
`default_nettype none

module thumbstick_radial_dead_zone (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_stall,
  input  wire trdz_pkg::sample_t sample,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output trdz_pkg::result_t      result,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata
);
  import trdz_pkg::*;

  logic en;
  logic [15:0] dz_radius;

  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dz_radius <= DZ_RESET;
    end else if (cfg_we) begin
      dz_radius <= cfg_wdata;
    end
  end

  // s1: odd magnitudes
  logic signed [16:0] ax, ay;
  logic [16:0] abs_x, abs_y;
  always_comb begin
    ax    = {sample.raw_x, 1'b1};
    ay    = {sample.raw_y, 1'b1};
    abs_x = ax[16] ? 17'(-ax) : 17'(ax);
    abs_y = ay[16] ? 17'(-ay) : 17'(ay);
  end

  logic     v1;
  sq_side_t s1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= sample_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1.mag_x <= abs_x[MAG_W-1:0];
      s1.mag_y <= abs_y[MAG_W-1:0];
      s1.sx    <= sample.raw_x[15];
      s1.sy    <= sample.raw_y[15];
      s1.dz    <= (dz_radius > DZ_MAX) ? DZ_MAX : dz_radius;
    end
  end

  // s2: squares
  logic        v2;
  sq_side_t    s2;
  logic [31:0] sq_x, sq_y;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_x <= 32'(s1.mag_x) * 32'(s1.mag_x);
      sq_y <= 32'(s1.mag_y) * 32'(s1.mag_y);
      s2   <= s1;
    end
  end

  // s3: sum of squares
  logic             v3;
  sq_side_t         s3;
  logic [SUM_W-1:0] sum;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SUM_W'(sq_x) + SUM_W'(sq_y);
      s3  <= s2;
    end
  end

  logic           vq;
  logic [M_W-1:0] m;
  sq_side_t       sq;

  trdz_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .in_v     (sum),
    .in_side  (s3),
    .out_valid(vq),
    .out_m    (m),
    .out_side (sq)
  );

  // s4: dead zone test and products
  logic              dead;
  logic [M_W-1:0]    diff;
  always_comb begin
    dead = m < M_W'(sq.dz);
    diff = dead ? '0 : m - M_W'(sq.dz);
  end

  logic              v4;
  dv_side_t          d4;
  logic [PROD_W-1:0] px, py;
  logic [DEN_W-1:0]  den4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vq;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px      <= PROD_W'(sq.mag_x) * PROD_W'(diff);
      py      <= PROD_W'(sq.mag_y) * PROD_W'(diff);
      den4    <= DEN_W'(m) * DEN_W'(16'(FULL_SCALE - sq.dz));
      d4.sx   <= sq.sx;
      d4.sy   <= sq.sy;
      d4.dead <= dead;
    end
  end

  // s5: times 32767
  logic             v5;
  dv_side_t         d5;
  logic [NUM_W-1:0] nx, ny;
  logic [DEN_W-1:0] den5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx   <= {px, Q_BITS'(0)} - NUM_W'(px);
      ny   <= {py, Q_BITS'(0)} - NUM_W'(py);
      den5 <= den4;
      d5   <= d4;
    end
  end

  logic              vd;
  logic [Q_BITS-1:0] qx, qy;
  logic              stx, sty;
  dv_side_t          dd;

  trdz_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v5),
    .num_x    (nx),
    .num_y    (ny),
    .den      (den5),
    .in_side  (d5),
    .out_valid(vd),
    .q_x      (qx),
    .q_y      (qy),
    .sat_x    (stx),
    .sat_y    (sty),
    .out_side (dd)
  );

  // output: clamp, sign, dead zone
  logic [15:0] cx, cy;
  always_comb begin
    cx = stx ? Q15_MAX : 16'(qx);
    cy = sty ? Q15_MAX : 16'(qy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vd;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      result.out_x        <= dd.dead ? '0 : (dd.sx ? -$signed(cx) : $signed(cx));
      result.out_y        <= dd.dead ? '0 : (dd.sy ? -$signed(cy) : $signed(cy));
      result.in_dead_zone <= dd.dead;
    end
  end

endmodule

`default_nettype wire

@@ rtl/trdz_checker.sv @@
// ----------------------------------------------------------------------------
// trdz_checker
// Port-level checks for the thumbstick radial dead zone block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trdz_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              sample_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire trdz_pkg::result_t result
);
  import trdz_pkg::*;

  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.in_dead_zone |-> result.out_x == 16'sd0 && result.out_y == 16'sd0)
    else $error("dead zone result not zero");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.out_x != 16'sh8000 && result.out_y != 16'sh8000)
    else $error("result out of Q1.15 range");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("request stalled without downstream stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind thumbstick_radial_dead_zone trdz_checker u_trdz_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_stall(sample_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

`default_nettype wire
